FILE: src/cardet_pkg.sv
// Package for the client abuse rate detector.
// Holds the profile codes, per-kind limits and windows, and the controller/datapath structs.
// No dependencies.
package cardet_pkg;

    localparam int EVENT_KINDS = 4;
    localparam int KIND_W = 2;
    localparam int PROF_W = 2;
    localparam int CMP_W = 8;

    localparam logic [PROF_W-1:0] PROF_OFF = 2'd0;
    localparam logic [PROF_W-1:0] PROF_CONSERVATIVE = 2'd1;
    localparam logic [PROF_W-1:0] PROF_STRICT = 2'd2;

    localparam logic [KIND_W-1:0] SCAN_KIND = 2'd2;

    localparam logic [63:0] SEC_NS = 64'd1000000000;
    localparam logic [63:0] COOLDOWN_NS = 64'd60 * SEC_NS;

    typedef struct packed {
        logic accept;
        logic srch_init;
        logic srch_chk;
        logic upd;
        logic cnt_load;
        logic prune;
        logic shift_init;
        logic shift;
        logic shift_wr;
        logic app;
        logic bmp_init;
        logic bmp_chk;
        logic cool_chk;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic ignore;
        logic match;
        logic last;
        logic scan_nopath;
        logic i_end;
        logic full;
        logic m_last;
        logic below_lim;
        logic is_scan;
        logic bmp_ok;
        logic out_free;
    } t_sts;

    function automatic logic [CMP_W-1:0] kind_limit(logic [PROF_W-1:0] prof,
                                                    logic [KIND_W-1:0] kind);
        logic [CMP_W-1:0] lim;
        if (prof == PROF_STRICT) begin
            unique case (kind)
                2'd0: lim = 8'd4;
                2'd1: lim = 8'd4;
                2'd2: lim = 8'd20;
                default: lim = 8'd2;
            endcase
        end else begin
            unique case (kind)
                2'd0: lim = 8'd8;
                2'd1: lim = 8'd8;
                2'd2: lim = 8'd40;
                default: lim = 8'd3;
            endcase
        end
        return lim;
    endfunction

    function automatic logic [63:0] kind_window(logic [KIND_W-1:0] kind);
        logic [63:0] w;
        unique case (kind)
            2'd0: w = 64'd60 * SEC_NS;
            2'd1: w = 64'd60 * SEC_NS;
            2'd2: w = 64'd30 * SEC_NS;
            default: w = 64'd600 * SEC_NS;
        endcase
        return w;
    endfunction

    function automatic logic [CMP_W-1:0] scan_need(logic [PROF_W-1:0] prof);
        return (prof == PROF_STRICT) ? 8'd16 : 8'd32;
    endfunction

endpackage

FILE: src/cardet_ram.sv
// Generic simple dual-port RAM with a registered read.
// One write port and one read port; no dependencies.
module cardet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/cardet_ctrl.sv
// Controller state machine of the client abuse rate detector.
// Sequences search, prune, shift, bitmap and cooldown steps; uses cardet_pkg.
module cardet_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cardet_pkg::t_sts  i_sts,
    output cardet_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SRD, S_SCHK, S_UPD, S_CNT, S_PRD, S_PCHK, S_MRD,
        S_MWR, S_APP, S_LIM, S_BRD, S_BCHK, S_LRD, S_LCHK, S_FIN
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.srch_init = 1'b1;
                    n_state = i_sts.ignore ? S_FIN : S_SRD;
                end
            end
            S_SRD: n_state = S_SCHK;
            S_SCHK: begin
                o_cmd.srch_chk = 1'b1;
                n_state = (i_sts.match || i_sts.last) ? S_UPD : S_SRD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state = i_sts.scan_nopath ? S_FIN : S_CNT;
            end
            S_CNT: begin
                o_cmd.cnt_load = 1'b1;
                n_state = S_PRD;
            end
            S_PRD: begin
                if (i_sts.i_end) begin
                    if (i_sts.full) begin
                        o_cmd.shift_init = 1'b1;
                        n_state = S_MRD;
                    end else begin
                        n_state = S_APP;
                    end
                end else begin
                    n_state = S_PCHK;
                end
            end
            S_PCHK: begin
                o_cmd.prune = 1'b1;
                n_state = S_PRD;
            end
            S_MRD: begin
                o_cmd.shift = 1'b1;
                n_state = S_MWR;
            end
            S_MWR: begin
                o_cmd.shift = 1'b1;
                o_cmd.shift_wr = 1'b1;
                n_state = i_sts.m_last ? S_APP : S_MRD;
            end
            S_APP: begin
                o_cmd.app = 1'b1;
                n_state = S_LIM;
            end
            S_LIM: begin
                if (i_sts.below_lim) begin
                    n_state = S_FIN;
                end else if (i_sts.is_scan) begin
                    o_cmd.bmp_init = 1'b1;
                    n_state = S_BRD;
                end else begin
                    n_state = S_LRD;
                end
            end
            S_BRD: begin
                if (i_sts.i_end) begin
                    n_state = i_sts.bmp_ok ? S_LRD : S_FIN;
                end else begin
                    n_state = S_BCHK;
                end
            end
            S_BCHK: begin
                o_cmd.bmp_chk = 1'b1;
                n_state = S_BRD;
            end
            S_LRD: n_state = S_LCHK;
            S_LCHK: begin
                o_cmd.cool_chk = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: src/cardet_dp.sv
// Datapath of the client abuse rate detector: client table, histories and signal totals.
// Uses cardet_pkg and cardet_ram; driven by cardet_ctrl.
module cardet_dp #(
    parameter int TABLE_ENTRIES = 64,
    parameter int HISTORY_DEPTH = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_wdata,
    input  logic              i_client_valid,
    input  logic [63:0]       i_client_addr_high,
    input  logic [63:0]       i_client_addr_low,
    input  logic [1:0]        i_event_kind,
    input  logic              i_path_present,
    input  logic [7:0]        i_path_hash,
    input  logic [63:0]       i_now_ns,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_flagged,
    output logic [63:0]       o_signal_total,
    input  cardet_pkg::t_cmd  i_cmd,
    output cardet_pkg::t_sts  o_sts
);

    localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int CAW = EW + cardet_pkg::KIND_W;
    localparam int HT_DEPTH = TABLE_ENTRIES * cardet_pkg::EVENT_KINDS * HISTORY_DEPTH;
    localparam int HAW = $clog2(HT_DEPTH);
    localparam int SH_DEPTH = TABLE_ENTRIES * HISTORY_DEPTH;
    localparam int SAW = $clog2(SH_DEPTH);

    logic [1:0]   r_prof;
    logic [63:0]  r_kh, r_kl, r_now;
    logic [1:0]   r_kind;
    logic         r_path;
    logic [7:0]   r_ph;
    logic [EW-1:0] r_idx, r_vic, r_e, n_vic;
    logic [63:0]  r_vic_ls, n_vic_ls;
    logic         r_found;
    logic [TABLE_ENTRIES-1:0] r_used, r_sig;
    logic [(2**CAW)-1:0] r_hv;
    logic [CW-1:0] r_cnt, r_i, r_kept;
    logic [255:0] r_bmp;
    logic [CW-1:0] r_bits;
    logic         r_flag;
    logic [63:0]  r_tot [cardet_pkg::EVENT_KINDS];
    logic         r_ovalid, r_oflag;
    logic [63:0]  r_ototal;

    logic [127:0] key_rd;
    logic [63:0]  ls_rd, lst_rd, ht_rd;
    logic [CW-1:0] hc_rd;
    logic [7:0]   sh_rd;
    logic [CAW-1:0] ck_addr;
    logic [HAW-1:0] ht_base, ht_raddr, ht_waddr;
    logic [SAW-1:0] sh_base, sh_raddr, sh_waddr;
    logic [CW-1:0] rd_off;
    logic [63:0]  ht_wdata;
    logic [7:0]   sh_wdata;
    logic         ht_we, sh_we, keep, used_i, match, blocked, scan;

    assign scan = (r_kind == cardet_pkg::SCAN_KIND);
    assign ck_addr = {r_e, r_kind};
    assign ht_base = HAW'(ck_addr * HISTORY_DEPTH);
    assign sh_base = SAW'(r_e * HISTORY_DEPTH);
    assign rd_off = i_cmd.shift ? r_i + CW'(1) : r_i;
    assign ht_raddr = ht_base + HAW'(rd_off);
    assign sh_raddr = sh_base + SAW'(rd_off);
    assign ht_waddr = ht_base + HAW'(i_cmd.shift_wr ? r_i : r_kept);
    assign sh_waddr = sh_base + SAW'(i_cmd.shift_wr ? r_i : r_kept);
    assign ht_wdata = i_cmd.app ? r_now : ht_rd;
    assign sh_wdata = i_cmd.app ? r_ph : sh_rd;
    assign keep = (r_now >= ht_rd) && ((r_now - ht_rd) < cardet_pkg::kind_window(r_kind));
    assign ht_we = (i_cmd.prune && keep) || i_cmd.shift_wr || i_cmd.app;
    assign sh_we = scan && ht_we;

    assign used_i = r_used[r_idx];
    assign match = used_i && (key_rd == {r_kh, r_kl});
    assign blocked = r_sig[r_e] && (r_now >= lst_rd) &&
                     ((r_now - lst_rd) < cardet_pkg::COOLDOWN_NS);

    always_comb begin
        n_vic = r_vic;
        n_vic_ls = r_vic_ls;
        priority if (r_idx == '0) begin
            n_vic = '0;
            n_vic_ls = ls_rd;
        end else if (!used_i) begin
            n_vic = r_idx;
        end else if (r_used[r_vic] && (ls_rd < r_vic_ls)) begin
            n_vic = r_idx;
            n_vic_ls = ls_rd;
        end
    end

    cardet_ram #(.WIDTH(128), .DEPTH(TABLE_ENTRIES)) u_key (
        .i_clk(i_clk), .i_we(i_cmd.upd && !r_found), .i_waddr(r_e),
        .i_wdata({r_kh, r_kl}), .i_raddr(r_idx), .o_rdata(key_rd)
    );

    cardet_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_seen (
        .i_clk(i_clk), .i_we(i_cmd.upd), .i_waddr(r_e),
        .i_wdata(r_now), .i_raddr(r_idx), .o_rdata(ls_rd)
    );

    cardet_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_sigt (
        .i_clk(i_clk), .i_we(i_cmd.cool_chk && !blocked), .i_waddr(r_e),
        .i_wdata(r_now), .i_raddr(r_e), .o_rdata(lst_rd)
    );

    cardet_ram #(.WIDTH(CW), .DEPTH(2**CAW)) u_hcnt (
        .i_clk(i_clk), .i_we(i_cmd.app), .i_waddr(ck_addr),
        .i_wdata(r_kept + CW'(1)), .i_raddr(ck_addr), .o_rdata(hc_rd)
    );

    cardet_ram #(.WIDTH(64), .DEPTH(HT_DEPTH)) u_hist (
        .i_clk(i_clk), .i_we(ht_we), .i_waddr(ht_waddr),
        .i_wdata(ht_wdata), .i_raddr(ht_raddr), .o_rdata(ht_rd)
    );

    cardet_ram #(.WIDTH(8), .DEPTH(SH_DEPTH)) u_hash (
        .i_clk(i_clk), .i_we(sh_we), .i_waddr(sh_waddr),
        .i_wdata(sh_wdata), .i_raddr(sh_raddr), .o_rdata(sh_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prof <= cardet_pkg::PROF_CONSERVATIVE;
            r_used <= '0;
            r_sig <= '0;
            r_hv <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < cardet_pkg::EVENT_KINDS; k++) begin
                r_tot[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_prof <= i_cfg_wdata;
            end
            if (i_cmd.upd && !r_found) begin
                r_used[r_e] <= 1'b1;
                r_sig[r_e] <= 1'b0;
                for (int k = 0; k < cardet_pkg::EVENT_KINDS; k++) begin
                    r_hv[{r_e, cardet_pkg::KIND_W'(k)}] <= 1'b0;
                end
            end
            if (i_cmd.app) begin
                r_hv[ck_addr] <= 1'b1;
            end
            if (i_cmd.cool_chk && !blocked) begin
                r_sig[r_e] <= 1'b1;
                r_tot[r_kind] <= r_tot[r_kind] + 64'd1;
            end
            if (i_cmd.fin) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kh <= i_client_addr_high;
            r_kl <= i_client_addr_low;
            r_kind <= i_event_kind;
            r_path <= i_path_present;
            r_ph <= i_path_hash;
            r_now <= i_now_ns;
            r_flag <= 1'b0;
        end
        if (i_cmd.srch_init) begin
            r_idx <= '0;
            r_vic <= '0;
        end
        if (i_cmd.srch_chk) begin
            r_idx <= r_idx + EW'(1);
            r_vic <= n_vic;
            r_vic_ls <= n_vic_ls;
            r_found <= match;
            r_e <= match ? r_idx : n_vic;
        end
        if (i_cmd.cnt_load) begin
            r_cnt <= !r_hv[ck_addr] ? '0 :
                     (hc_rd > CW'(HISTORY_DEPTH)) ? CW'(HISTORY_DEPTH) : hc_rd;
            r_i <= '0;
            r_kept <= '0;
        end
        if (i_cmd.prune) begin
            r_i <= r_i + CW'(1);
            if (keep) begin
                r_kept <= r_kept + CW'(1);
            end
        end
        if (i_cmd.shift_init) begin
            r_i <= '0;
        end
        if (i_cmd.shift_wr) begin
            r_i <= r_i + CW'(1);
            if (o_sts.m_last) begin
                r_kept <= CW'(HISTORY_DEPTH - 1);
            end
        end
        if (i_cmd.app) begin
            r_cnt <= r_kept + CW'(1);
        end
        if (i_cmd.bmp_init) begin
            r_bmp <= '0;
            r_bits <= '0;
            r_i <= '0;
        end
        if (i_cmd.bmp_chk) begin
            r_bmp[sh_rd] <= 1'b1;
            if (!r_bmp[sh_rd]) begin
                r_bits <= r_bits + CW'(1);
            end
            r_i <= r_i + CW'(1);
        end
        if (i_cmd.cool_chk && !blocked) begin
            r_flag <= 1'b1;
        end
        if (i_cmd.fin) begin
            r_oflag <= r_flag;
            r_ototal <= r_tot[r_kind];
        end
    end

    always_comb begin
        o_sts.ignore = !i_client_valid || (r_prof == cardet_pkg::PROF_OFF);
        o_sts.match = match;
        o_sts.last = (r_idx == EW'(TABLE_ENTRIES - 1));
        o_sts.scan_nopath = scan && !r_path;
        o_sts.i_end = (r_i == r_cnt);
        o_sts.full = (r_kept == CW'(HISTORY_DEPTH));
        o_sts.m_last = (r_i == CW'(HISTORY_DEPTH - 2));
        o_sts.below_lim = (cardet_pkg::CMP_W'(r_cnt) < cardet_pkg::kind_limit(r_prof, r_kind));
        o_sts.is_scan = scan;
        o_sts.bmp_ok = (cardet_pkg::CMP_W'(r_bits) >= cardet_pkg::scan_need(r_prof));
        o_sts.out_free = !r_ovalid || i_ready;
    end

    assign o_valid = r_ovalid;
    assign o_flagged = r_oflag;
    assign o_signal_total = r_ototal;

endmodule

FILE: src/client_abuse_rate_detector.sv
// Top level of the client abuse rate detector.
// Instantiates cardet_ctrl and cardet_dp; uses cardet_pkg.
//
// One event item enters on the input channel (i_valid/o_ready) and exactly one
// result item leaves on the output channel (o_valid/i_ready): a flag and the
// running signal total for the event's kind.
// The profile register is written through i_cfg_we/i_cfg_wdata; the user must
// write it only while the block is idle, as the block itself does not enforce this.
// It resets to conservative, and profile zero ignores every event. Items are
// handled one at a time. An ignored item goes straight to its result. Otherwise the
// key search reads one table entry at a time (up to TABLE_ENTRIES entries), the
// history prune reads each stored timestamp, a full history is shifted down by one
// entry, and a scan event that reaches its limit reads each stored path hash for
// the distinct-path count. All of these steps go through the single read port of
// each table memory. The result is held in an output register; the next item is
// accepted while it waits, and that item completes once the register has been taken.
// Reset clears the client table, counts and totals at once; no sweep is needed.
module client_abuse_rate_detector #(
    parameter int TABLE_ENTRIES = 64,
    parameter int HISTORY_DEPTH = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_client_valid,
    input  logic [63:0] i_client_addr_high,
    input  logic [63:0] i_client_addr_low,
    input  logic [1:0]  i_event_kind,
    input  logic        i_path_present,
    input  logic [7:0]  i_path_hash,
    input  logic [63:0] i_now_ns,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_flagged,
    output logic [63:0] o_signal_total
);

    cardet_pkg::t_cmd cmd;
    cardet_pkg::t_sts sts;

    cardet_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    cardet_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_client_valid(i_client_valid), .i_client_addr_high(i_client_addr_high),
        .i_client_addr_low(i_client_addr_low), .i_event_kind(i_event_kind),
        .i_path_present(i_path_present), .i_path_hash(i_path_hash), .i_now_ns(i_now_ns),
        .i_ready(i_ready), .o_valid(o_valid), .o_flagged(o_flagged),
        .o_signal_total(o_signal_total), .i_cmd(cmd), .o_sts(sts)
    );

`ifndef SYNTH
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("item accepted while another is in progress");

    a_flag_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_flagged) |-> (o_signal_total != 64'd0))
        else $error("flagged result with zero signal total");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("block not idle after reset");
`endif

endmodule
